/* rtl/msbh_pkg.sv */
// ----------------------------------------------------------------------------
// msbh_pkg: shared types and hash functions
// one-at-a-time hash steps, fold and the bucket width for the signature hash
// ----------------------------------------------------------------------------
package msbh_pkg;

   localparam int TABLE_SIZE = 64;
   localparam int BUCKET_W   = $clog2(TABLE_SIZE);
   localparam int HASH_W     = 32;
   localparam int BYTE_W     = 8;
   localparam int TDATA_W    = 8;

   typedef logic [HASH_W-1:0]   hash_type;
   typedef logic [BUCKET_W-1:0] bucket_type;

   // one input byte item as held in the input register
   typedef struct packed {
      logic [BYTE_W-1:0] byte_value;
      logic              byte_present;
      logic              last_of_string;
   } item_type;

   // hash stage to bucket stage
   typedef struct packed {
      logic     pair_done;
      hash_type name_hash;
      hash_type type_hash;
   } pair_type;

   // add sign-extended byte, then the usual shift/add/xor mix
   function automatic hash_type mix_byte(hash_type h, logic [BYTE_W-1:0] b);
      hash_type v;
      v = h + {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
      v = v + (v << 10);
      v = v ^ (v >> 6);
      return v;
   endfunction

   function automatic hash_type finish_hash(hash_type h);
      hash_type v;
      v = h + (h << 3);
      v = v ^ (v >> 11);
      v = v + (v << 15);
      return v;
   endfunction

   function automatic hash_type fold32(hash_type h);
      return (h >> 24) ^ (h >> 16) ^ (h >> 8) ^ h;
   endfunction

endpackage

/* rtl/msbh_hash_state.sv */
// ----------------------------------------------------------------------------
// msbh_hash_state: running string hash
// holds the running hash, the finished name hash and the string phase
// ----------------------------------------------------------------------------
module msbh_hash_state import msbh_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     step_en,
   input  item_type item,
   output pair_type pair
);

   hash_type running_hash_ff, running_hash_in;
   hash_type saved_name_hash_ff, saved_name_hash_in;
   logic     in_second_ff, in_second_in;
   hash_type mixed;
   hash_type done;

   always_comb begin
      mixed = item.byte_present ? mix_byte(running_hash_ff, item.byte_value)
                                : running_hash_ff;
      done  = finish_hash(mixed);
   end

   always_comb begin
      running_hash_in    = running_hash_ff;
      saved_name_hash_in = saved_name_hash_ff;
      in_second_in       = in_second_ff;
      if (step_en) begin
         if (!item.last_of_string) begin
            running_hash_in = mixed;
         end else begin
            running_hash_in = '0;
            if (!in_second_ff) begin
               saved_name_hash_in = done;
               in_second_in       = 1'b1;
            end else begin
               saved_name_hash_in = '0;
               in_second_in       = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_hash_ff    <= '0;
         saved_name_hash_ff <= '0;
         in_second_ff       <= 1'b0;
      end else begin
         running_hash_ff    <= running_hash_in;
         saved_name_hash_ff <= saved_name_hash_in;
         in_second_ff       <= in_second_in;
      end
   end

   assign pair.pair_done = item.last_of_string & in_second_ff;
   assign pair.name_hash = saved_name_hash_ff;
   assign pair.type_hash = done;

endmodule

/* rtl/msbh_bucket_reg.sv */
// ----------------------------------------------------------------------------
// msbh_bucket_reg: fold and result register
// folds both hashes, reduces to a bucket and holds it for the receiver
// ----------------------------------------------------------------------------
module msbh_bucket_reg import msbh_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  pair_type   pair,
   input  logic       out_ready,
   output logic       out_valid,
   output bucket_type out_bucket,
   output logic       slot_free
);

   logic       valid_ff, valid_in;
   bucket_type bucket_ff, bucket_in;
   hash_type   comb;

   // table size is a power of two, so the modulo is the low bits
   assign comb      = fold32(pair.name_hash) ^ fold32(pair.type_hash);
   assign slot_free = !valid_ff || out_ready;

   always_comb begin
      valid_in  = valid_ff;
      bucket_in = bucket_ff;
      if (load) begin
         valid_in  = 1'b1;
         bucket_in = comb[BUCKET_W-1:0];
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bucket_ff <= bucket_in;
   end

   assign out_valid  = valid_ff;
   assign out_bucket = bucket_ff;

endmodule

/* rtl/method_signature_bucket_hash_core.sv */
// ----------------------------------------------------------------------------
// method_signature_bucket_hash_core: method signature bucket hash
// hashes a method name and its type descriptor into a table bucket
// ----------------------------------------------------------------------------
// usage
//   req channel carries one string byte per request: first the method name,
//   then the type descriptor. req_tlast ends a string; req_tuser low means
//   the request carries no byte, so a string may be empty.
//   rsp channel carries one bucket index per name/type pair, sent on the
//   request that ends the type string. other requests give no response.
// throughput and pipeline
//   one request per cycle, except while a request that ends a type string waits
//   for the result slot. a request is held in the input register; the hash step
//   and fold run between that register and the bucket register, which drives rsp.
//   the per-byte hash recurrence closes through the running hash register.
// reset
//   synchronous, active high: clears both hashes, the string phase and both
//   valid flags; the next byte starts a new method name.
// stalls
//   while a bucket waits on rsp, bytes that end no pair keep flowing; only
//   the request that ends a type string waits for the result slot.
// ----------------------------------------------------------------------------
module method_signature_bucket_hash_core import msbh_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,   // [7:0] byte_value
   input  logic               req_tuser,   // [0] byte_present
   input  logic               req_tlast,   // last_of_string
   // response channel
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata    // [5:0] bucket, [7:6] zero
);

   logic       in_valid_ff, in_valid_in;
   item_type   item_ff, item_in;
   logic       req_accept;
   logic       advance;
   logic       load;
   logic       slot_free;
   pair_type   pair;
   bucket_type bucket;

   assign req_accept = req_tvalid && req_tready;

   // the held request moves on unless it ends a pair and the slot is full
   assign advance    = in_valid_ff && (!pair.pair_done || slot_free);
   assign load       = advance && pair.pair_done;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (req_accept) begin
         in_valid_in            = 1'b1;
         item_in.byte_value     = req_tdata[BYTE_W-1:0];
         item_in.byte_present   = req_tuser;
         item_in.last_of_string = req_tlast;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   msbh_hash_state u_hash (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .pair    (pair)
   );

   msbh_bucket_reg u_bucket (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .pair       (pair),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_bucket (bucket),
      .slot_free  (slot_free)
   );

   assign rsp_tdata = {{(TDATA_W-BUCKET_W){1'b0}}, bucket};

   // a held request that is not moved on stays held
   a_hold_input : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(item_ff))
      else $error("input request dropped while stalled");

   // bytes that end no pair never wait on the response side
   a_no_false_stall : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !pair.pair_done |-> advance)
      else $error("non-final request stalled");

   // a bucket is written only into a free result slot
   a_load_free : assert property (@(posedge clock) disable iff (reset)
      load |-> slot_free)
      else $error("result overwritten before taken");

   // a loaded bucket is offered in the next cycle
   a_load_shows : assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_tvalid)
      else $error("loaded bucket not offered");

endmodule
